/* hdl/swrm_pkg.sv */
// Shared types and constants for the sliding-window rate meter.
// No dependencies; every other file in hdl/ imports this package.
package swrm_pkg;

	localparam int unsigned RING_DEPTH_DEFAULT = 64;

	// Reset values of the configuration registers.
	localparam logic [15:0] ADD_INTERVAL_RST = 16'd1000;
	localparam logic [19:0] WINDOW_RST       = 20'd10000;
	localparam logic [15:0] MIN_AGE_RST      = 16'd2000;

	// Milliseconds per second, used to scale the byte sum.
	localparam logic [9:0] MS_PER_S = 10'd1000;

	// A 32-bit sum times 1000 fits in 42 bits.
	localparam int unsigned PROD_W = 42;

	// Configuration register indexes.
	localparam logic [1:0] CFG_ADD_INTERVAL = 2'd0;
	localparam logic [1:0] CFG_WINDOW       = 2'd1;
	localparam logic [1:0] CFG_MIN_AGE      = 2'd2;

	// Request kinds carried on the input tuser.
	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_CLEAR  = 1'b1;

	// One ring entry as stored in the sample memory.
	typedef struct packed {
		logic [31:0] bytes;
		logic [31:0] tick;
	} entry_t;

endpackage

/* hdl/sliding_window_rate_meter.sv */
// Sliding-window average rate meter: top level with sequencer, ring and divider.
// Depends on swrm_pkg, swrm_ring and swrm_div.
//
//  channel | signals                                  | beat carries
//  --------+------------------------------------------+------------------------------
//  s_      | s_tvalid s_tready s_tdata s_tuser        | one sample or clear request
//  m_      | m_tvalid m_tready m_tdata                | rate, window sum, overflow
//  cfg_    | cfg_valid cfg_ready cfg_index cfg_data   | one register write
//
// A clear beat goes straight to the finish state. A sample beat passes through sequencing
// and ring access, plus a read and compare per entry evicted; when a rate is computed, it
// also starts the divider and waits for the bit-serial divider's 42 quotient bits.
// The ring memory has one read port, so the newest-tick check, the full-ring eviction
// and each window eviction each issue a read of their own. One item is processed at a time.
// Reset is asynchronous and empties the ring; the memory itself needs no clearing.
// The result waits in the output register while the next input beat is taken.
module sliding_window_rate_meter
	import swrm_pkg::*;
#(
	parameter int unsigned RING_DEPTH = RING_DEPTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,   // now_ms[31:0], sent_bytes[63:32], slot_age_ms[95:64]
	input  logic        s_tuser,   // req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // rate_bytes_per_s[31:0], window_sum[63:32],
	                               // ring_overflow[64], zero fill[71:65]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [19:0] cfg_data
);

	localparam int unsigned AW = $clog2(RING_DEPTH);
	localparam int unsigned CW = $clog2(RING_DEPTH + 1);
	localparam int unsigned PW = CW + 1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_NEWEST_RD,
		S_NEWEST_CMP,
		S_APP_RD,
		S_APP,
		S_EV_RD,
		S_EV_CMP,
		S_MUL,
		S_DIV,
		S_FIN
	} state_t;

	state_t        state_q;
	logic [15:0]   add_q;
	logic [19:0]   win_q;
	logic [15:0]   min_q;
	logic [31:0]   now_q;
	logic [31:0]   sent_q;
	logic [31:0]   age_q;
	logic [31:0]   span_q;
	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [31:0]   sum_q;
	logic [31:0]   rate_q;
	logic          ovf_q;
	logic          m_tvalid_q;
	logic [71:0]   m_tdata_q;

	logic [PW-1:0]     newest_sum;
	logic [PW-1:0]     slot_sum;
	logic [AW-1:0]     newest_idx;
	logic [AW-1:0]     slot_idx;
	logic [AW-1:0]     head_next;
	logic              full;
	logic [31:0]       head_age;
	entry_t            rd_data;
	entry_t            wr_data;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [AW-1:0]     rd_addr;
	logic              div_start;
	logic              div_done;
	logic [PROD_W-1:0] dividend;
	logic [PROD_W-1:0] quotient;
	logic              out_free;

	always_comb begin
		newest_sum = PW'(head_q) + PW'(count_q) - PW'(1);
		slot_sum   = PW'(head_q) + PW'(count_q);
		newest_idx = (newest_sum >= PW'(RING_DEPTH)) ?
			AW'(newest_sum - PW'(RING_DEPTH)) : AW'(newest_sum);
		slot_idx   = (slot_sum >= PW'(RING_DEPTH)) ?
			AW'(slot_sum - PW'(RING_DEPTH)) : AW'(slot_sum);
		head_next  = (head_q == AW'(RING_DEPTH - 1)) ? '0 : head_q + AW'(1);
		full       = count_q == CW'(RING_DEPTH);
		head_age   = now_q - rd_data.tick;
		rd_addr    = (state_q == S_NEWEST_RD) ? newest_idx : head_q;
		wr_en      = state_q == S_APP;
		// On a full ring the new entry takes the slot of the one it evicts.
		wr_addr    = full ? head_q : slot_idx;
		wr_data    = '{bytes: sent_q, tick: now_q};
		div_start  = state_q == S_MUL;
		dividend   = PROD_W'(sum_q) * PROD_W'(MS_PER_S);
		out_free   = !m_tvalid_q || m_tready;
	end

	swrm_ring #(
		.RING_DEPTH(RING_DEPTH)
	) u_ring (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	swrm_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(dividend),
		.divisor (span_q),
		.done    (div_done),
		.quotient(quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			add_q <= ADD_INTERVAL_RST;
			win_q <= WINDOW_RST;
			min_q <= MIN_AGE_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_ADD_INTERVAL: add_q <= cfg_data[15:0];
				CFG_WINDOW:       win_q <= cfg_data;
				CFG_MIN_AGE:      min_q <= cfg_data[15:0];
				default:          ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			head_q     <= '0;
			count_q    <= '0;
			sum_q      <= '0;
			ovf_q      <= 1'b0;
			rate_q     <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			now_q      <= '0;
			sent_q     <= '0;
			age_q      <= '0;
			span_q     <= '0;
		end else begin
			// A new result replaces the one leaving in the same cycle.
			if (state_q == S_FIN && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						now_q  <= s_tdata[31:0];
						sent_q <= s_tdata[63:32];
						age_q  <= s_tdata[95:64];
						ovf_q  <= 1'b0;
						rate_q <= '0;
						if (s_tuser == REQ_CLEAR) begin
							head_q  <= '0;
							count_q <= '0;
							sum_q   <= '0;
							state_q <= S_FIN;
						end else if (s_tdata[63:32] != '0 || count_q == '0) begin
							state_q <= S_APP_RD;
						end else begin
							state_q <= S_NEWEST_RD;
						end
					end
				end
				S_NEWEST_RD: state_q <= S_NEWEST_CMP;
				S_NEWEST_CMP: begin
					if ((now_q - rd_data.tick) > {16'd0, add_q}) begin
						state_q <= S_APP_RD;
					end else begin
						state_q <= S_EV_RD;
					end
				end
				S_APP_RD: state_q <= S_APP;
				S_APP: begin
					if (full) begin
						sum_q  <= sum_q - rd_data.bytes + sent_q;
						head_q <= head_next;
						ovf_q  <= 1'b1;
					end else begin
						sum_q   <= sum_q + sent_q;
						count_q <= count_q + CW'(1);
					end
					state_q <= S_EV_RD;
				end
				S_EV_RD: state_q <= S_EV_CMP;
				S_EV_CMP: begin
					priority if (count_q == '0) begin
						state_q <= S_FIN;
					end else if (head_age > {12'd0, win_q}) begin
						sum_q   <= sum_q - rd_data.bytes;
						head_q  <= head_next;
						count_q <= count_q - CW'(1);
						state_q <= S_EV_RD;
					end else if (head_age != '0 && age_q > {16'd0, min_q}) begin
						span_q  <= head_age;
						state_q <= S_MUL;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_MUL: state_q <= S_DIV;
				S_DIV: begin
					if (div_done) begin
						rate_q  <= (quotient[PROD_W-1:32] != '0) ? '1 : quotient[31:0];
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						m_tdata_q <= {7'd0, ovf_q, sum_q, rate_q};
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_tready  = state_q == S_IDLE;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(RING_DEPTH))
		else $error("entry count exceeds ring depth");

	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= AW'(RING_DEPTH - 1))
		else $error("head index outside ring");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser == REQ_CLEAR) |=> (count_q == '0 && sum_q == '0))
		else $error("clear beat left entries in the ring");

	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == S_FIN))
		else $error("result loaded outside the finish state");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("divider finished while not awaited");

endmodule

/* hdl/swrm_ring.sv */
// Sample ring storage: one write port and one registered read port.
// Depends on swrm_pkg for the entry type.
module swrm_ring
	import swrm_pkg::*;
#(
	parameter int unsigned RING_DEPTH = RING_DEPTH_DEFAULT
) (
	input  logic                          clk,
	input  logic                          wr_en,
	input  logic [$clog2(RING_DEPTH)-1:0] wr_addr,
	input  entry_t                        wr_data,
	input  logic [$clog2(RING_DEPTH)-1:0] rd_addr,
	output entry_t                        rd_data
);

	entry_t mem_q [RING_DEPTH];
	entry_t rd_q;

	// Entries have no reset; the sequencer uses read data only from entries that were written.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_q;

endmodule

/* hdl/swrm_div.sv */
// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
// Depends on swrm_pkg for the dividend width.
module swrm_div
	import swrm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [PROD_W-1:0] dividend,
	input  logic [31:0]       divisor,
	output logic              done,
	output logic [PROD_W-1:0] quotient
);

	localparam int unsigned CNT_W = $clog2(PROD_W + 1);

	logic [PROD_W-1:0] quot_q;
	logic [31:0]       rem_q;
	logic [31:0]       div_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [32:0] trial;
	logic        fits;
	logic [32:0] diff;

	always_comb begin
		trial = {rem_q, quot_q[PROD_W-1]};
		diff  = trial - {1'b0, div_q};
		fits  = trial >= {1'b0, div_q};
	end

	// The quotient register doubles as the dividend shift register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(PROD_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
			div_q  <= divisor;
		end else if (busy_q) begin
			quot_q <= {quot_q[PROD_W-2:0], fits};
			rem_q  <= fits ? diff[31:0] : trial[31:0];
		end
	end

	assign done     = done_q;
	assign quotient = quot_q;

endmodule

/* tb/sv/swrm_checker.sv */
`timescale 1ns / 1ps
// Result checker for the sliding-window rate meter: watches the input, result and
// register write channels, keeps its own copy of the sample ring and compares beats.
// Depends on swrm_pkg for register indexes, request kinds and reset values.
module swrm_checker
	import swrm_pkg::*;
#(
	parameter int unsigned DEPTH = RING_DEPTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [95:0] s_tdata,   // now_ms[31:0], sent_bytes[63:32], slot_age_ms[95:64]
	input  logic        s_tuser,   // req_type
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [71:0] m_tdata,   // rate_bytes_per_s[31:0], window_sum[63:32],
	                               // ring_overflow[64], zero fill[71:65]
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [19:0] cfg_data,
	output int          errors,
	output int          pending
);

	localparam int AW = $clog2(DEPTH);

	typedef struct packed {
		logic [31:0] rate;
		logic [31:0] sum;
		logic        overflow;
	} rate_result_t;

	logic [31:0]   hist_bytes [DEPTH];
	logic [31:0]   hist_tick  [DEPTH];
	logic [AW-1:0] oldest;
	logic [AW:0]   fill;
	logic [31:0]   total;
	logic [15:0]   add_interval;
	logic [19:0]   window;
	logic [15:0]   min_age;
	rate_result_t  awaited_results [$];
	int            mismatches;

	function automatic int ring_slot(int offset);
		return (int'(oldest) + offset) % DEPTH;
	endfunction

	task automatic retire_oldest();
		total  = total - hist_bytes[oldest];
		oldest = AW'(ring_slot(1));
		fill   = fill - 1'b1;
	endtask

	task automatic predict_rate(input logic req, input logic [31:0] now,
			input logic [31:0] sent, input logic [31:0] age, output rate_result_t res);
		logic        append;
		logic [31:0] gap;
		int          slot;
		logic [63:0] quotient;
		res = '0;
		if (req == REQ_CLEAR) begin
			oldest = '0;
			fill   = '0;
			total  = '0;
			return;
		end
		append = (sent != 0) || (fill == 0);
		if (!append) begin
			gap    = now - hist_tick[ring_slot(int'(fill) - 1)];
			append = gap > {16'd0, add_interval};
		end
		if (append) begin
			// A full ring gives up its oldest entry to make room for the new one.
			if (fill >= DEPTH) begin
				retire_oldest();
				res.overflow = 1'b1;
			end
			slot = ring_slot(int'(fill));
			hist_bytes[slot] = sent;
			hist_tick[slot]  = now;
			fill  = fill + 1'b1;
			total = total + sent;
		end
		while (fill != 0 && (now - hist_tick[oldest]) > {12'd0, window})
			retire_oldest();
		if (fill != 0) begin
			gap = now - hist_tick[oldest];
			if (gap != 0 && age > {16'd0, min_age}) begin
				quotient = ({32'd0, total} * MS_PER_S) / {32'd0, gap};
				res.rate = (quotient > 64'hFFFF_FFFF) ? '1 : quotient[31:0];
			end
		end
		res.sum = total;
	endtask

	always @(posedge clk or negedge arst_n) begin
		rate_result_t want;
		rate_result_t got;
		if (!arst_n) begin
			oldest       = '0;
			fill         = '0;
			total        = '0;
			add_interval = ADD_INTERVAL_RST;
			window       = WINDOW_RST;
			min_age      = MIN_AGE_RST;
			mismatches   = 0;
			awaited_results.delete();
			errors  <= 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_ADD_INTERVAL: add_interval = cfg_data[15:0];
					CFG_WINDOW:       window = cfg_data;
					CFG_MIN_AGE:      min_age = cfg_data[15:0];
					default: ;
				endcase
			end
			// A result beat always belongs to an older input beat, so compare first.
			if (m_tvalid && m_tready) begin
				got = {m_tdata[31:0], m_tdata[63:32], m_tdata[64]};
				if (awaited_results.size() == 0) begin
					$display("%0t: result beat with nothing expected, got rate %0d sum %0d overflow %0d",
						$time, got.rate, got.sum, got.overflow);
					mismatches++;
				end else begin
					want = awaited_results.pop_front();
					if (got.rate !== want.rate) begin
						$display("%0t: rate mismatch, expected %0d, got %0d",
							$time, want.rate, got.rate);
						mismatches++;
					end
					if (got.sum !== want.sum) begin
						$display("%0t: window sum mismatch, expected %0d, got %0d",
							$time, want.sum, got.sum);
						mismatches++;
					end
					if (got.overflow !== want.overflow) begin
						$display("%0t: ring overflow mismatch, expected %0d, got %0d",
							$time, want.overflow, got.overflow);
						mismatches++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				predict_rate(s_tuser, s_tdata[31:0], s_tdata[63:32], s_tdata[95:64], want);
				awaited_results.push_back(want);
			end
			errors  <= mismatches;
			pending <= awaited_results.size();
		end
	end

endmodule

/* tb/sv/sliding_window_rate_meter_tb.sv */
`timescale 1ns / 1ps
// Testbench top for the sliding-window rate meter: clock, reset, register writes,
// sample and clear beats, random stalls on both streams and the verdict.
// Depends on swrm_pkg, swrm_checker and sliding_window_rate_meter.
module sliding_window_rate_meter_tb;
	import swrm_pkg::*;

	localparam logic [1:0] CFG_SPARE   = 2'd3;
	localparam int         PHASE_ITEMS = 210;
	localparam int         PHASES      = 8;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [95:0] s_tdata   = '0;
	logic        s_tuser   = 1'b0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [71:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [19:0] cfg_data  = '0;

	int          errors;
	int          pending;
	int          src_idle_pct  = 0;
	int          sink_idle_pct = 0;
	int          sink_hold     = 0;
	bit          calm          = 1'b0;
	logic [31:0] now_tick      = '0;
	logic [15:0] add_cur       = ADD_INTERVAL_RST;
	logic [19:0] win_cur       = WINDOW_RST;
	logic [15:0] min_cur       = MIN_AGE_RST;

	sliding_window_rate_meter uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	swrm_checker chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#6_000_000;
		$display("tb: failure");
		$finish;
	end

	// Result side: random stalls come in bursts, held by a countdown in sink_hold.
	always @(posedge clk) begin
		if (sink_hold > 0) begin
			sink_hold <= sink_hold - 1;
			m_tready  <= 1'b0;
		end else if (!calm && $urandom_range(99) < sink_idle_pct) begin
			sink_hold <= $urandom_range(12);
			m_tready  <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic push_beat(input logic req, input logic [31:0] now,
			input logic [31:0] sent, input logic [31:0] age);
		if (!calm && $urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(13, 1)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= {age, sent, now};
		do @(posedge clk); while (!s_tready);
	endtask

	// Waits until every result beat for the accepted input has come back.
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [19:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// The 16-bit registers get random upper data bits, which the block must drop.
	task automatic configure(input logic [15:0] add, input logic [19:0] win,
			input logic [15:0] min, input bit spare);
		drain();
		write_reg(CFG_ADD_INTERVAL, {4'($urandom_range(15)), add});
		write_reg(CFG_WINDOW, win);
		write_reg(CFG_MIN_AGE, {4'($urandom_range(15)), min});
		if (spare)
			write_reg(CFG_SPARE, 20'($urandom()));
		cfg_valid <= 1'b0;
		add_cur = add;
		win_cur = win;
		min_cur = min;
	endtask

	// Mostly small tick steps so the ring fills within the window, with some
	// steps past the add interval, past the window, and wild jumps across the wrap.
	task automatic random_item();
		logic [31:0] delta;
		logic [31:0] sent;
		logic [31:0] age;
		int          pick;
		if ($urandom_range(99) < 2) begin
			push_beat(REQ_CLEAR, $urandom(), $urandom(), $urandom());
			return;
		end
		pick = $urandom_range(99);
		if (pick < 70)
			delta = $urandom_range(win_cur / 48 + 1);
		else if (pick < 85)
			delta = $urandom_range(add_cur + 2);
		else if (pick < 97)
			delta = $urandom_range(win_cur + add_cur + 2);
		else
			delta = $urandom();
		now_tick = now_tick + delta;
		pick = $urandom_range(99);
		if (pick < 45)
			sent = '0;
		else if (pick < 85)
			sent = $urandom_range(5000);
		else
			sent = $urandom();
		pick = $urandom_range(99);
		if (pick < 40)
			age = min_cur + $urandom_range(2) - 1;
		else if (pick < 70)
			age = $urandom();
		else
			age = min_cur + $urandom_range(100000);
		push_beat(REQ_SAMPLE, now_tick, sent, age);
	endtask

	initial begin
		int p;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed beats under the reset register values.
		push_beat(REQ_SAMPLE, 32'd0, 32'd0, 32'd0);
		push_beat(REQ_SAMPLE, 32'd500, 32'd0, 32'd3000);
		push_beat(REQ_SAMPLE, 32'd1500, 32'd0, 32'd3000);
		push_beat(REQ_SAMPLE, 32'd2000, '1, '1);
		push_beat(REQ_SAMPLE, 32'd2001, '1, '1);
		push_beat(REQ_SAMPLE, 32'd2001, 32'd5, 32'd2000);
		push_beat(REQ_SAMPLE, 32'd2002, 32'd1, 32'd2001);
		push_beat(REQ_SAMPLE, 32'd13000, 32'd0, 32'd5000);
		push_beat(REQ_CLEAR, $urandom(), $urandom(), $urandom());
		push_beat(REQ_SAMPLE, 32'hFFFF_FFF0, 32'd100, '1);
		push_beat(REQ_SAMPLE, 32'h0000_0010, 32'd100, '1);
		push_beat(REQ_SAMPLE, 32'd30000, 32'd0, 32'd3000);
		push_beat(REQ_CLEAR, 32'd0, 32'd0, 32'd0);
		push_beat(REQ_SAMPLE, 32'd5000, 32'd0, 32'd4000);
		push_beat(REQ_SAMPLE, 32'd5001, 32'h1000_0000, 32'd4000);
		push_beat(REQ_SAMPLE, 32'd5001, 32'd0, '1);
		push_beat(REQ_CLEAR, '1, '1, '1);
		push_beat(REQ_SAMPLE, '1, '1, 32'd0);

		for (p = 0; p < PHASES; p++) begin
			case (p)
				0: begin
					configure(16'd0, 20'd0, 16'd0, 1'b1);
					src_idle_pct  = 30;
					sink_idle_pct = 30;
				end
				1: begin
					configure('1, '1, '1, 1'b0);
					src_idle_pct  = 20;
					sink_idle_pct = 40;
				end
				2: begin
					configure(ADD_INTERVAL_RST, WINDOW_RST, MIN_AGE_RST, 1'b1);
					src_idle_pct  = 0;
					sink_idle_pct = 0;
				end
				5: begin
					configure(16'd0, 20'd1, 16'd0, 1'b0);
					src_idle_pct  = 25;
					sink_idle_pct = 25;
				end
				7: begin
					configure(16'($urandom_range(3000)), 20'($urandom_range(30000, 100)),
						16'($urandom_range(5000)), 1'b1);
					calm = 1'b1;
				end
				default: begin
					configure(16'($urandom_range(3000)), 20'($urandom_range(30000, 100)),
						16'($urandom_range(5000)), bit'($urandom_range(1)));
					src_idle_pct  = $urandom_range(50);
					sink_idle_pct = $urandom_range(50);
				end
			endcase
			now_tick = $urandom();
			repeat (PHASE_ITEMS) random_item();
		end

		drain();
		repeat (200) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

/* sim.f */
hdl/swrm_pkg.sv
hdl/swrm_ring.sv
hdl/swrm_div.sv
hdl/sliding_window_rate_meter.sv
tb/sv/swrm_checker.sv
tb/sv/sliding_window_rate_meter_tb.sv
